>>> src/ratio_timer_with_alarm_assert.svh
// ----------------------------------------------------------------------------
// ratio timer assertion macros
// shorthand for clocked implication checks under an active-low reset
// ----------------------------------------------------------------------------
`ifndef RATIO_TIMER_WITH_ALARM_ASSERT_SVH
`define RATIO_TIMER_WITH_ALARM_ASSERT_SVH

// same-cycle implication
`define RTA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rta_pkg.sv
// ----------------------------------------------------------------------------
// rta_pkg
// shared widths, request and register codes, alarm helper functions
// ----------------------------------------------------------------------------
package rta_pkg;

    localparam int RATIO_BITS = 32;
    localparam int DATA_W     = 32;
    localparam int CNT_W      = 56;
    // count bits that make up the low register word (time bits 31..5)
    localparam int LOW_W      = 27;
    localparam int HIGH_W     = CNT_W - LOW_W;
    localparam int SHIFT_W    = DATA_W - LOW_W;
    // dividend is phase plus denominator, one bit wider than a ratio value
    localparam int ACC_W      = RATIO_BITS + 1;
    localparam int DIV_CNT_W  = $clog2(ACC_W);

    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    localparam logic [2:0] SEL_INTR    = 3'd0;
    localparam logic [2:0] SEL_INTR_EN = 3'd1;
    localparam logic [2:0] SEL_NUM     = 3'd2;
    localparam logic [2:0] SEL_DEN     = 3'd3;
    localparam logic [2:0] SEL_TIME_LO = 3'd4;
    localparam logic [2:0] SEL_TIME_HI = 3'd5;
    localparam logic [2:0] SEL_ALARM   = 3'd6;
    localparam logic [2:0] SEL_NONE    = 3'd7;

    localparam logic [DATA_W-1:0] ALARM_BIT = DATA_W'(1);

    typedef logic [CNT_W-1:0] count_t;

    // alarm placed in the current epoch, or the next one if not ahead of now
    function automatic count_t place_alarm(input count_t now, input logic [LOW_W-1:0] low);
        count_t target;
        target = {now[CNT_W-1:LOW_W], low};
        if (low <= now[LOW_W-1:0])
        begin
            target = target + (count_t'(1) << LOW_W);
        end
        return target;
    endfunction

    // distance zero or already passed (top bit of the wrapped distance set)
    function automatic logic alarm_reached(input count_t now, input count_t when_t);
        count_t lead_cnt;
        lead_cnt = when_t - now;
        return (lead_cnt == '0) || lead_cnt[CNT_W-1];
    endfunction

endpackage

>>> src/ratio_timer_with_alarm.sv
// ----------------------------------------------------------------------------
// ratio_timer_with_alarm
// register-mapped ratio timer with a self re-arming alarm, one result per item
// ----------------------------------------------------------------------------
// a running tick passes the divide, add and alarm states before its result;
// writes and reads of the pending register pass the alarm then the apply state,
// other reads only the apply state; a stopped tick, an unmapped write or an
// unknown request goes straight to the result. A new item is accepted only
// after the previous result is taken; the tick uses a radix-2 restoring divider
// reset: all timer state cleared, alarm disarmed, source clock marked present
// ----------------------------------------------------------------------------
`include "ratio_timer_with_alarm_assert.svh"

module ratio_timer_with_alarm
    import rta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration: source clock present
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    // request channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [2:0]        reg_sel,
    input  logic [DATA_W-1:0] write_data,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] read_data,
    output logic              irq,
    output logic              alarm_hit
);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1; // one quotient bit per cycle
    localparam logic [2:0] S_ADD   = 3'd2; // count += quotient
    localparam logic [2:0] S_ALARM = 3'd3; // alarm compare and latch
    localparam logic [2:0] S_APPLY = 3'd4; // register read or write
    localparam logic [2:0] S_DONE  = 3'd5; // result held until taken

    logic [2:0]            state_reg, state_next;

    // timer state
    count_t                count_reg, count_next;
    // phase doubles as the divider remainder during a tick
    logic [RATIO_BITS-1:0] phase_reg, phase_next;
    logic [RATIO_BITS-1:0] num_reg, num_next;
    logic [RATIO_BITS-1:0] den_reg, den_next;
    count_t                alarm_when_reg, alarm_when_next;
    logic                  alarm_on_reg, alarm_on_next;
    logic [DATA_W-1:0]     irq_en_reg, irq_en_next;
    logic [DATA_W-1:0]     pending_reg, pending_next;
    logic                  clk_on_reg;

    // divider: dividend shifts out as quotient shifts in
    logic [ACC_W-1:0]      quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    // captured transaction
    logic [1:0]            req_reg, req_next;
    logic [2:0]            sel_reg, sel_next;
    logic [DATA_W-1:0]     data_reg, data_next;

    // result
    logic [DATA_W-1:0]     rd_reg, rd_next;
    logic                  hit_reg, hit_next;

    logic                  running;
    logic [ACC_W-1:0]      trial;
    logic [ACC_W-1:0]      trial_diff;
    logic                  trial_ge;

    assign running = (num_reg != '0) && (den_reg != '0) && clk_on_reg;

    // subtract-and-compare step of the divider
    assign trial      = {phase_reg, quo_reg[ACC_W-1]};
    assign trial_ge   = trial >= ACC_W'(num_reg);
    assign trial_diff = trial - ACC_W'(num_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign read_data = rd_reg;
    assign alarm_hit = hit_reg;
    assign irq       = |(pending_reg & irq_en_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        alarm_when_next = alarm_when_reg;
        alarm_on_next   = alarm_on_reg;
        irq_en_next     = irq_en_reg;
        pending_next    = pending_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        req_next        = req_reg;
        sel_next        = sel_reg;
        data_next       = data_reg;
        rd_next         = rd_reg;
        hit_next        = hit_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next  = req_type;
                    sel_next  = reg_sel;
                    data_next = write_data;
                    rd_next   = '0;
                    hit_next  = 1'b0;
                    case (req_type)
                        REQ_TICK:
                        begin
                            if (running)
                            begin
                                // dividend = phase + den, remainder starts at zero
                                quo_next     = ACC_W'(phase_reg) + ACC_W'(den_reg);
                                phase_next   = '0;
                                div_cnt_next = DIV_CNT_W'(ACC_W - 1);
                                state_next   = S_DIV;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        REQ_READ:
                        begin
                            // reading the pending register checks the alarm first
                            state_next = (reg_sel == SEL_INTR) ? S_ALARM : S_APPLY;
                        end
                        REQ_WRITE:
                        begin
                            state_next = (reg_sel != SEL_NONE) ? S_ALARM : S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                phase_next = trial_ge ? trial_diff[RATIO_BITS-1:0] : trial[RATIO_BITS-1:0];
                quo_next   = {quo_reg[ACC_W-2:0], trial_ge};
                if (div_cnt_reg == '0)
                begin
                    state_next = S_ADD;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
            end
            S_ADD:
            begin
                count_next = count_reg + CNT_W'(quo_reg);
                state_next = S_ALARM;
            end
            S_ALARM:
            begin
                if (alarm_on_reg && running && alarm_reached(count_reg, alarm_when_reg))
                begin
                    pending_next    = pending_reg | ALARM_BIT;
                    // re-arm at the same low word, in the current epoch or the next one if not ahead of now
                    alarm_when_next = place_alarm(count_reg, alarm_when_reg[LOW_W-1:0]);
                    hit_next        = 1'b1;
                end
                state_next = (req_reg == REQ_TICK) ? S_DONE : S_APPLY;
            end
            S_APPLY:
            begin
                if (req_reg == REQ_READ)
                begin
                    case (sel_reg)
                        SEL_INTR:    rd_next = pending_reg;
                        SEL_INTR_EN: rd_next = irq_en_reg;
                        SEL_NUM:     rd_next = DATA_W'(num_reg);
                        SEL_DEN:     rd_next = DATA_W'(den_reg);
                        SEL_TIME_LO: rd_next = {count_reg[LOW_W-1:0], {SHIFT_W{1'b0}}};
                        SEL_TIME_HI: rd_next = DATA_W'(count_reg[CNT_W-1:LOW_W]);
                        SEL_ALARM:   rd_next = {alarm_when_reg[LOW_W-1:0], {SHIFT_W{1'b0}}};
                        default:     rd_next = '0;
                    endcase
                end
                else
                begin
                    case (sel_reg)
                        SEL_INTR:    pending_next = pending_reg & ~data_reg;
                        SEL_INTR_EN: irq_en_next = data_reg;
                        SEL_NUM:
                        begin
                            num_next   = data_reg[RATIO_BITS-1:0];
                            phase_next = '0;
                        end
                        SEL_DEN:
                        begin
                            den_next   = data_reg[RATIO_BITS-1:0];
                            phase_next = '0;
                        end
                        SEL_TIME_LO:
                        begin
                            count_next = {count_reg[CNT_W-1:LOW_W], data_reg[DATA_W-1:SHIFT_W]};
                        end
                        SEL_TIME_HI:
                        begin
                            count_next = {data_reg[HIGH_W-1:0], count_reg[LOW_W-1:0]};
                        end
                        SEL_ALARM:
                        begin
                            alarm_when_next = place_alarm(count_reg, data_reg[DATA_W-1:SHIFT_W]);
                            alarm_on_next   = 1'b1;
                        end
                        default:
                        begin
                            alarm_on_next = alarm_on_reg;
                        end
                    endcase
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            phase_reg      <= '0;
            num_reg        <= '0;
            den_reg        <= '0;
            alarm_when_reg <= '0;
            alarm_on_reg   <= 1'b0;
            irq_en_reg     <= '0;
            pending_reg    <= '0;
            clk_on_reg     <= 1'b1;
            div_cnt_reg    <= '0;
            rd_reg         <= '0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            num_reg        <= num_next;
            den_reg        <= den_next;
            alarm_when_reg <= alarm_when_next;
            alarm_on_reg   <= alarm_on_next;
            irq_en_reg     <= irq_en_next;
            pending_reg    <= pending_next;
            div_cnt_reg    <= div_cnt_next;
            rd_reg         <= rd_next;
            hit_reg        <= hit_next;
            if (cfg_wr_en)
            begin
                clk_on_reg <= cfg_wr_data;
            end
        end
    end

    // payload holding registers, no reset needed
    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        req_reg  <= req_next;
        sel_reg  <= sel_next;
        data_reg <= data_next;
    end

    // checks
    `RTA_ASSERT_NOW(a_ready_result_excl, in_ready, !out_valid, "ready while result pending")
    `RTA_ASSERT_NEXT(a_div_ends, (state_reg == S_DIV) && (div_cnt_reg == '0),
                     state_reg == S_ADD, "divider overran")
    `RTA_ASSERT_NOW(a_phase_below_num, (state_reg == S_ALARM) && (req_reg == REQ_TICK),
                    phase_reg < num_reg, "remainder not below numerator")
    `RTA_ASSERT_NOW(a_hit_needs_armed, out_valid && alarm_hit, alarm_on_reg,
                    "alarm hit while disarmed")
    `RTA_ASSERT_NEXT(a_ready_after_take, out_valid && out_ready, in_ready,
                     "not ready after result taken")

endmodule
